FILE: rtl/rdr_pkg.sv
package rdr_pkg;

	// Operands are taken from the low OPW bits of each 32-bit field as two's complement.
	localparam int OPW = 32;
	localparam int FW = 32;

	// Width of a product magnitude and of the operands and results of the gcd and divide engine.
	localparam int PW = 2 * OPW - 1;
	localparam int SW = PW + 1;
	localparam int CW = $clog2(PW);

	localparam int RES_NUM_W = 64;
	localparam int RES_DEN_W = 63;
	localparam int S_DATA_W = 4 * FW;
	localparam int M_DATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;
	localparam int M_PAD_W = M_DATA_W - RES_NUM_W - RES_DEN_W;

	localparam logic FN_REDUCE = 1'b0;
	localparam logic FN_DIVIDE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_N,
		S_MUL_D,
		S_CHECK,
		S_RUN,
		S_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_GCD,
		E_DIVN,
		E_DIVD
	} eng_state_t;

endpackage

FILE: rtl/rdr_engine.sv
module rdr_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [rdr_pkg::PW-1:0] nm,
	input  logic [rdr_pkg::PW-1:0] dm,
	output logic                  done,
	output logic [rdr_pkg::PW-1:0] rn,
	output logic [rdr_pkg::PW-1:0] rd
);
	import rdr_pkg::*;

	eng_state_t    state_q, state_d;
	logic [PW-1:0] u_q, u_d, v_q, v_d;
	logic [PW-1:0] nm_q, nm_d, dm_q, dm_d;
	logic [PW-1:0] rem_q, rem_d, dq_q, dq_d;
	logic [PW-1:0] rn_q, rn_d, rd_q, rd_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          done_q, done_d;

	// The one shared subtractor: u - v during the gcd, trial remainder - g while dividing.
	logic [SW-1:0] sub_a, sub_b;
	logic [SW:0]   diff;
	logic          borrow;
	logic [PW-1:0] step_rem, step_dq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		u_q   <= u_d;
		v_q   <= v_d;
		nm_q  <= nm_d;
		dm_q  <= dm_d;
		rem_q <= rem_d;
		dq_q  <= dq_d;
		cnt_q <= cnt_d;
		rn_q  <= rn_d;
		rd_q  <= rd_d;
	end

	always_comb begin
		if (state_q == E_DIVN || state_q == E_DIVD) begin
			sub_a = {rem_q, dq_q[PW-1]};
			sub_b = {1'b0, u_q};
		end else begin
			sub_a = {1'b0, u_q};
			sub_b = {1'b0, v_q};
		end
		diff   = {1'b0, sub_a} - {1'b0, sub_b};
		borrow = diff[SW];

		// One restoring division step: the quotient bit enters where the dividend leaves.
		if (!borrow) begin
			step_rem = diff[PW-1:0];
			step_dq  = {dq_q[PW-2:0], 1'b1};
		end else begin
			step_rem = sub_a[PW-1:0];
			step_dq  = {dq_q[PW-2:0], 1'b0};
		end

		state_d = state_q;
		u_d     = u_q;
		v_d     = v_q;
		nm_d    = nm_q;
		dm_d    = dm_q;
		rem_d   = rem_q;
		dq_d    = dq_q;
		cnt_d   = cnt_q;
		rn_d    = rn_q;
		rd_d    = rd_q;
		done_d  = 1'b0;

		unique case (state_q)
			E_IDLE: begin
				if (start) begin
					u_d     = nm;
					v_d     = dm;
					nm_d    = nm;
					dm_d    = dm;
					state_d = E_GCD;
				end
			end
			E_GCD: begin
				if (!u_q[0] && !v_q[0]) begin
					// A common factor of two leaves the fraction as well, so the
					// gcd never has to be shifted back up.
					u_d  = u_q >> 1;
					v_d  = v_q >> 1;
					nm_d = nm_q >> 1;
					dm_d = dm_q >> 1;
				end else if (!u_q[0]) begin
					u_d = u_q >> 1;
				end else if (!v_q[0]) begin
					v_d = v_q >> 1;
				end else if (diff == '0) begin
					rem_d   = '0;
					dq_d    = nm_q;
					cnt_d   = CW'(PW - 1);
					state_d = E_DIVN;
				end else if (borrow) begin
					u_d = v_q;
					v_d = u_q;
				end else begin
					u_d = diff[PW:1];
				end
			end
			E_DIVN: begin
				rem_d = step_rem;
				dq_d  = step_dq;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					rn_d    = step_dq;
					rem_d   = '0;
					dq_d    = dm_q;
					cnt_d   = CW'(PW - 1);
					state_d = E_DIVD;
				end
			end
			E_DIVD: begin
				rem_d = step_rem;
				dq_d  = step_dq;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					rd_d    = step_dq;
					done_d  = 1'b1;
					state_d = E_IDLE;
				end
			end
			default: state_d = E_IDLE;
		endcase
	end

	assign done = done_q;
	assign rn   = rn_q;
	assign rd   = rd_q;

endmodule

FILE: rtl/rational_divide_reduce_unit.sv
// Rational reduce and divide. Each input beat carries an operation in s_tuser (reduce
// a_num/a_den, or divide a_num/a_den by b_num/b_den) and the output beat carries one
// fraction in lowest terms with a positive denominator and the sign on the numerator,
// plus a status: ok, zero denominator (result 0/1) or divide by zero (result 1/1, which
// is checked before anything else). A zero numerator gives 0/1 with ok status. One item
// is in flight at a time and s_tready is high only while the unit is idle. A normal
// item is accepted, forms its two products on the shared 32x32 multiplier, passes a
// check state, runs a binary gcd on one shared subtractor (each step strips a factor of
// two, swaps, or subtracts, and the length depends on the bit lengths of the two
// products), then two restoring divisions of PW = 63 quotient bits each on the same
// subtractor, and goes through the output state to the output register. Zero and
// error cases skip the gcd engine. A finished result sits in the output register, so
// the next beat is accepted while it waits for m_tready.
module rational_divide_reduce_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// a_num, a_den, b_num, b_den from the lowest bit up, 32 bits each
	input  logic [rdr_pkg::S_DATA_W-1:0]  s_tdata,
	// func
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// res_num (64 bits), res_den (63 bits), then one zero pad bit, from the lowest bit up
	output logic [rdr_pkg::M_DATA_W-1:0]  m_tdata,
	// status
	output logic [1:0]                    m_tuser
);
	import rdr_pkg::*;

	function automatic logic [OPW-1:0] mag_of(input logic [OPW-1:0] x);
		mag_of = x[OPW-1] ? (~x + 1'b1) : x;
	endfunction

	top_state_t       state_q, state_d;

	// Operand fields, cut down to their low OPW bits.
	logic [OPW-1:0]   an_in, ad_in, bn_in, bd_in;
	logic             divz_in, neg_in, accept;

	logic             func_q, neg_q, divz_q;
	logic [OPW-1:0]   man_q, mad_q, mbn_q, mbd_q;
	logic [PW-1:0]    nm_q, dm_q;

	logic [OPW-1:0]   mul_a, mul_b;
	logic [2*OPW-1:0] prod;

	logic             eng_start, eng_done;
	logic [PW-1:0]    eng_rn, eng_rd;

	logic                 load_out;
	logic [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0] res_den;
	status_t              res_status;

	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic [1:0]           m_tuser_q;

	assign an_in = s_tdata[OPW-1:0];
	assign ad_in = s_tdata[FW+OPW-1:FW];
	assign bn_in = s_tdata[2*FW+OPW-1:2*FW];
	assign bd_in = s_tdata[3*FW+OPW-1:3*FW];

	// Divide by a zero fraction is decided from the divisor numerator alone.
	assign divz_in = (s_tuser[0] == FN_DIVIDE) && (bn_in == '0);

	// The sign of the quotient is the parity of the four operand signs.
	assign neg_in = (s_tuser[0] == FN_DIVIDE) ?
		(an_in[OPW-1] ^ ad_in[OPW-1] ^ bn_in[OPW-1] ^ bd_in[OPW-1]) :
		(an_in[OPW-1] ^ ad_in[OPW-1]);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser[0];
			neg_q  <= neg_in;
			divz_q <= divz_in;
			man_q  <= mag_of(an_in);
			mad_q  <= mag_of(ad_in);
			mbn_q  <= mag_of(bn_in);
			mbd_q  <= mag_of(bd_in);
		end
	end

	// One multiplier forms both magnitudes. Reduce multiplies by one, so both
	// operations hand the gcd engine the same kind of numerator and denominator.
	always_comb begin
		mul_a = (state_q == S_MUL_D) ? mad_q : man_q;
		if (func_q == FN_DIVIDE) begin
			mul_b = (state_q == S_MUL_D) ? mbn_q : mbd_q;
		end else begin
			mul_b = OPW'(1);
		end
		prod = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL_N) begin
			nm_q <= prod[PW-1:0];
		end
		if (state_q == S_MUL_D) begin
			dm_q <= prod[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		eng_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = divz_in ? S_OUT : S_MUL_N;
				end
			end
			S_MUL_N: state_d = S_MUL_D;
			S_MUL_D: state_d = S_CHECK;
			S_CHECK: begin
				if (dm_q == '0 || nm_q == '0) begin
					state_d = S_OUT;
				end else begin
					eng_start = 1'b1;
					state_d   = S_RUN;
				end
			end
			S_RUN: begin
				if (eng_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// Wait here only while an earlier result has not been taken.
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	rdr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.nm     (nm_q),
		.dm     (dm_q),
		.done   (eng_done),
		.rn     (eng_rn),
		.rd     (eng_rd)
	);

	// Result selection in order of precedence: divide by zero, zero denominator,
	// zero numerator, then the reduced fraction.
	always_comb begin
		if (divz_q) begin
			res_num    = RES_NUM_W'(1);
			res_den    = RES_DEN_W'(1);
			res_status = ST_DIV_ZERO;
		end else if (dm_q == '0) begin
			res_num    = '0;
			res_den    = RES_DEN_W'(1);
			res_status = ST_ZERO_DEN;
		end else if (nm_q == '0) begin
			res_num    = '0;
			res_den    = RES_DEN_W'(1);
			res_status = ST_OK;
		end else begin
			res_num    = neg_q ? (~RES_NUM_W'(eng_rn) + 1'b1) : RES_NUM_W'(eng_rn);
			res_den    = RES_DEN_W'(eng_rd);
			res_status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {{M_PAD_W{1'b0}}, res_den, res_num};
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: rtl/rdr_checker.sv
module rdr_assertions (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [rdr_pkg::S_DATA_W-1:0] s_tdata,
	input logic [0:0]                   s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [rdr_pkg::M_DATA_W-1:0] m_tdata,
	input logic [1:0]                   m_tuser
);
	import rdr_pkg::*;

	logic [RES_NUM_W-1:0] num;
	logic [RES_DEN_W-1:0] den;

	assign num = m_tdata[RES_NUM_W-1:0];
	assign den = m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W];

	// A divide by zero always reports exactly 1/1.
	a_div_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DIV_ZERO |-> num == RES_NUM_W'(1) && den == RES_DEN_W'(1))
		else $error("divide by zero result is not 1/1");

	// A zero denominator always reports 0/1.
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_ZERO_DEN |-> num == '0 && den == RES_DEN_W'(1))
		else $error("zero denominator result is not 0/1");

	// Any zero numerator is normalized to a denominator of one.
	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && num == '0 |-> den == RES_DEN_W'(1))
		else $error("zero result without denominator one");

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

endmodule

bind rational_divide_reduce_unit rdr_assertions u_rdr_assertions (.*);
